// ===== hdl/rps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rps_pkg
// Shared constants and types for the routing parent set table.
// ----------------------------------------------------------------------------
package rps_pkg;
    localparam int NUM_PARENTS = 4;
    localparam int IDX_W       = $clog2(NUM_PARENTS);
    localparam logic [15:0] RANK_INF = 16'hffff;
    localparam int CLASS_SHIFT = 3;
    localparam logic [15:0] HOP_RESET = 16'd1024;

    typedef struct packed {
        logic [15:0] rank;
        logic [15:0] addr;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        t_entry           wr_data;
        logic             clr_en;
        logic [IDX_W-1:0] clr_idx;
        logic             clr_tail;
    } t_mem_req;
endpackage
`default_nettype wire

// ===== hdl/rps_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rps_mem
// Parent list storage: one write and one registered read per cycle,
// per-entry valid bits so an unwritten entry reads as empty.
// ----------------------------------------------------------------------------
module rps_mem
    import rps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mem_req i_req,
    output t_entry        o_rd_data
);
    t_entry                 r_mem [NUM_PARENTS];
    logic [NUM_PARENTS-1:0] r_valid;
    t_entry                 r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_idx];
            end
            for (int k = 0; k < NUM_PARENTS; k++) begin
                if ((i_req.clr_tail && k != 0) ||
                    (i_req.clr_en && i_req.clr_idx == IDX_W'(k))) begin
                    r_valid[k] <= 1'b0;
                end
                if (i_req.wr_en && i_req.wr_idx == IDX_W'(k)) begin
                    r_valid[k] <= 1'b1;
                end
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : t_entry'{rank: RANK_INF, addr: RANK_INF};
endmodule
`default_nettype wire

// ===== hdl/rps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rps_ctrl
// Sequencer: reads the head of the list, decides the update, sweeps the
// list for refresh or removal with shifting, and presents the result.
// ----------------------------------------------------------------------------
module rps_ctrl
    import rps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_sender_address,
    input  wire logic [15:0] i_advertised_rank,
    input  wire logic [15:0] i_offered_rank,
    input  wire logic [15:0] i_max_hop,
    input  wire t_entry      i_rd_data,
    output t_mem_req         o_req,
    output logic             o_busy,
    output logic             o_done,
    output logic [15:0]      o_own_rank,
    output logic [15:0]      o_preferred_parent,
    output logic [15:0]      o_preferred_parent_rank,
    output logic             o_preferred_changed,
    output logic             o_preferred_removed,
    output logic             o_rank_class_differs
);
    typedef enum logic [2:0] {S_IDLE, S_HEAD, S_HEAD1, S_SWEEP, S_FIN, S_OUT} t_state;

    t_state           r_state, n_state;
    logic [15:0]      r_sa, r_ar, r_off, r_node, r_min, r_old;
    logic [15:0]      n_node, n_min;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_found, n_found, r_removed, n_removed, r_drop, n_drop;
    logic             r_chk_rm, n_chk_rm;
    logic             r_done;
    logic [15:0]      r_own, r_pp, r_ppr;
    logic             r_chg, r_rm, r_diff;

    logic [15:0] oc, rc;
    logic        inf, last, hit;
    logic [16:0] limit;

    always_comb begin
        oc    = r_off >> CLASS_SHIFT;
        rc    = r_node >> CLASS_SHIFT;
        inf   = r_off == RANK_INF;
        last  = r_idx == IDX_W'(NUM_PARENTS - 1);
        hit   = !r_found && i_rd_data.addr == r_sa;
        limit = {1'b0, r_min} + {1'b0, i_max_hop};
    end

    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_min     = r_min;
        n_idx     = r_idx;
        n_found   = r_found;
        n_removed = r_removed;
        n_drop    = r_drop;
        n_chk_rm  = r_chk_rm;
        o_req     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_min        = (i_offered_rank < r_min) ? i_offered_rank : r_min;
                    n_found      = 1'b0;
                    n_removed    = 1'b0;
                    o_req.rd_en  = 1'b1;
                    o_req.rd_idx = '0;
                    n_state      = S_HEAD;
                end
            end
            S_HEAD: begin
                o_req.rd_en  = 1'b1;
                o_req.rd_idx = IDX_W'(1);
                n_state      = S_HEAD1;
            end
            S_HEAD1: begin
                n_state = S_FIN;
                if (inf || (oc > rc && i_rd_data.rank != RANK_INF)) begin
                    n_drop       = 1'b1;
                    n_chk_rm     = inf;
                    n_idx        = '0;
                    o_req.rd_en  = 1'b1;
                    o_req.rd_idx = '0;
                    n_state      = S_SWEEP;
                end else if (oc < rc) begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_idx  = '0;
                    o_req.wr_data = t_entry'{rank: r_ar, addr: r_sa};
                    o_req.clr_tail = 1'b1;
                    n_node        = r_off;
                end else if (oc == rc) begin
                    n_drop       = 1'b0;
                    n_idx        = '0;
                    o_req.rd_en  = 1'b1;
                    o_req.rd_idx = '0;
                    n_state      = S_SWEEP;
                end else if (r_old == r_sa) begin
                    o_req.wr_en  = 1'b1;
                    o_req.wr_idx = '0;
                    if ({1'b0, r_off} < limit) begin
                        o_req.wr_data = t_entry'{rank: r_ar, addr: r_old};
                        n_node        = r_off;
                    end else begin
                        o_req.wr_data = t_entry'{rank: RANK_INF, addr: r_old};
                        n_node        = RANK_INF;
                        n_min         = RANK_INF;
                    end
                end
            end
            S_SWEEP: begin
                if (!last) begin
                    o_req.rd_en  = 1'b1;
                    o_req.rd_idx = r_idx + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (r_drop) begin
                    if (r_found) begin
                        o_req.wr_en   = 1'b1;
                        o_req.wr_idx  = r_idx - 1'b1;
                        o_req.wr_data = i_rd_data;
                    end
                    if (hit) begin
                        n_found = 1'b1;
                        if (r_idx == '0 && r_chk_rm) begin
                            n_removed = 1'b1;
                        end
                    end
                    if (last) begin
                        if (r_found || hit) begin
                            o_req.clr_en  = 1'b1;
                            o_req.clr_idx = r_idx;
                        end
                        n_state = S_FIN;
                    end
                end else begin
                    if (i_rd_data.addr == r_sa) begin
                        o_req.wr_en   = 1'b1;
                        o_req.wr_idx  = r_idx;
                        o_req.wr_data = t_entry'{rank: r_ar, addr: i_rd_data.addr};
                        n_state       = S_FIN;
                    end else if (i_rd_data.rank == RANK_INF) begin
                        o_req.wr_en   = 1'b1;
                        o_req.wr_idx  = r_idx;
                        o_req.wr_data = t_entry'{rank: r_ar, addr: r_sa};
                        n_state       = S_FIN;
                    end else if (last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                o_req.rd_en  = 1'b1;
                o_req.rd_idx = '0;
                n_state      = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_node    <= RANK_INF;
            r_min     <= RANK_INF;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_removed <= 1'b0;
            r_drop    <= 1'b0;
            r_chk_rm  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_node    <= n_node;
            r_min     <= n_min;
            r_idx     <= n_idx;
            r_found   <= n_found;
            r_removed <= n_removed;
            r_drop    <= n_drop;
            r_chk_rm  <= n_chk_rm;
            r_done    <= r_state == S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_sa  <= i_sender_address;
            r_ar  <= i_advertised_rank;
            r_off <= i_offered_rank;
        end
        if (r_state == S_HEAD) begin
            r_old <= i_rd_data.addr;
        end
        if (r_state == S_OUT) begin
            r_own  <= r_node;
            r_pp   <= i_rd_data.addr;
            r_ppr  <= i_rd_data.rank;
            r_chg  <= i_rd_data.addr != r_old;
            r_rm   <= r_removed;
            r_diff <= !inf && ((r_node >> CLASS_SHIFT) != oc);
        end
    end

    assign o_busy                  = r_state != S_IDLE;
    assign o_done                  = r_done;
    assign o_own_rank              = r_own;
    assign o_preferred_parent      = r_pp;
    assign o_preferred_parent_rank = r_ppr;
    assign o_preferred_changed     = r_chg;
    assign o_preferred_removed     = r_rm;
    assign o_rank_class_differs    = r_diff;
endmodule
`default_nettype wire

// ===== hdl/routing_parent_set_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// routing_parent_set_table_top
// Neighbor advertisement processing over a small ordered parent list.
//
// Input: an advertisement word (sender address, advertised rank, offered
// rank) is taken at a clock edge with i_start high and o_busy low.
// Output: one result word per advertisement, shown for one cycle with
// o_done high; the receiver takes it unconditionally.
// A better or sole-parent update is decided from the head of the list
// alone, while a refresh or a removal also sweeps the list; the
// result is shown in the first cycle with o_busy low. A new advertisement
// is taken only while o_busy is low. The parent list lives in a
// single-port-read memory, one entry read per cycle, which sets the sweep.
// A new advertisement may start in the cycle the result is shown.
// Configuration: APB register 0 (max_hop_increase) at byte address 0,
// written while the block is idle; pready is always high.
// Reset: synchronous, active low; clears the list to empty, ranks to
// infinite and max_hop_increase to 1024. No clearing pass is needed.
// ----------------------------------------------------------------------------
module routing_parent_set_table_top
    import rps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_sender_address,
    input  wire logic [15:0] i_advertised_rank,
    input  wire logic [15:0] i_offered_rank,
    output logic             o_busy,
    output logic             o_done,
    output logic [15:0]      o_own_rank,
    output logic [15:0]      o_preferred_parent,
    output logic [15:0]      o_preferred_parent_rank,
    output logic             o_preferred_changed,
    output logic             o_preferred_removed,
    output logic             o_rank_class_differs,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [15:0] r_max_hop;
    t_mem_req    req;
    t_entry      rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hop <= HOP_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_max_hop <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_max_hop};

    rps_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    rps_ctrl u_ctrl (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_start                 (i_start),
        .i_sender_address        (i_sender_address),
        .i_advertised_rank       (i_advertised_rank),
        .i_offered_rank          (i_offered_rank),
        .i_max_hop               (r_max_hop),
        .i_rd_data               (rd_data),
        .o_req                   (req),
        .o_busy                  (o_busy),
        .o_done                  (o_done),
        .o_own_rank              (o_own_rank),
        .o_preferred_parent      (o_preferred_parent),
        .o_preferred_parent_rank (o_preferred_parent_rank),
        .o_preferred_changed     (o_preferred_changed),
        .o_preferred_removed     (o_preferred_removed),
        .o_rank_class_differs    (o_rank_class_differs)
    );
endmodule
`default_nettype wire

// ===== tb/sv/rps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_checker
// Watches advertisement words and APB writes, predicts each result word of
// the parent set table and compares it field by field with the block output.
// ----------------------------------------------------------------------------
module rps_checker
    import rps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [15:0] i_sender_address,
    input  wire logic [15:0] i_advertised_rank,
    input  wire logic [15:0] i_offered_rank,
    input  wire logic        i_done,
    input  wire logic [15:0] i_own_rank,
    input  wire logic [15:0] i_preferred_parent,
    input  wire logic [15:0] i_preferred_parent_rank,
    input  wire logic        i_preferred_changed,
    input  wire logic        i_preferred_removed,
    input  wire logic        i_rank_class_differs,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_errors,
    output int               o_pending,
    output int               o_words_in,
    output int               o_words_out
);
    localparam logic [2:0] ADDR_MAX_HOP = 3'd0;

    typedef struct packed {
        logic [15:0] own_rank;
        logic [15:0] pref;
        logic [15:0] pref_rank;
        logic        changed;
        logic        removed;
        logic        differs;
    } t_result;

    logic [15:0] rank_tbl [NUM_PARENTS];
    logic [15:0] addr_tbl [NUM_PARENTS];
    logic [15:0] node_rank, min_rank, hop_limit;
    t_result     expected_q[$];

    function automatic bit remove_parent(input logic [15:0] a);
        int hit;
        hit = -1;
        for (int k = 0; k < NUM_PARENTS; k++)
            if (hit < 0 && addr_tbl[k] == a) hit = k;
        if (hit < 0) return 0;
        for (int k = hit; k < NUM_PARENTS - 1; k++) begin
            rank_tbl[k] = rank_tbl[k+1];
            addr_tbl[k] = addr_tbl[k+1];
        end
        rank_tbl[NUM_PARENTS-1] = RANK_INF;
        addr_tbl[NUM_PARENTS-1] = RANK_INF;
        return hit == 0;
    endfunction

    function automatic t_result predict_advert(input logic [15:0] sa, ar, off);
        t_result r;
        logic [15:0] old_pref, oc, rc;
        logic [16:0] limit;
        bit removed, differs, hit;
        old_pref = addr_tbl[0];
        removed = 0;
        differs = 0;
        if (min_rank > off) min_rank = off;
        if (off == RANK_INF) begin
            removed = remove_parent(sa);
        end else begin
            oc = off >> CLASS_SHIFT;
            rc = node_rank >> CLASS_SHIFT;
            if (oc < rc) begin
                rank_tbl[0] = ar;
                addr_tbl[0] = sa;
                node_rank = off;
                for (int k = 1; k < NUM_PARENTS; k++) begin
                    rank_tbl[k] = RANK_INF;
                    addr_tbl[k] = RANK_INF;
                end
            end else if (oc == rc) begin
                hit = 0;
                for (int k = 0; k < NUM_PARENTS; k++) begin
                    if (!hit && addr_tbl[k] == sa) begin
                        rank_tbl[k] = ar;
                        hit = 1;
                    end else if (!hit && rank_tbl[k] == RANK_INF) begin
                        rank_tbl[k] = ar;
                        addr_tbl[k] = sa;
                        hit = 1;
                    end
                end
            end else if (rank_tbl[1] == RANK_INF) begin
                if (addr_tbl[0] == sa) begin
                    limit = {1'b0, min_rank} + {1'b0, hop_limit};
                    if ({1'b0, off} < limit) begin
                        rank_tbl[0] = ar;
                        node_rank = off;
                    end else begin
                        rank_tbl[0] = RANK_INF;
                        node_rank = RANK_INF;
                        min_rank = RANK_INF;
                    end
                end
            end else begin
                void'(remove_parent(sa));
            end
            differs = (node_rank >> CLASS_SHIFT) != oc;
        end
        r.own_rank = node_rank;
        r.pref = addr_tbl[0];
        r.pref_rank = rank_tbl[0];
        r.changed = addr_tbl[0] != old_pref;
        r.removed = removed;
        r.differs = differs;
        return r;
    endfunction

    t_result got, exp_r;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PARENTS; k++) begin
                rank_tbl[k] = RANK_INF;
                addr_tbl[k] = RANK_INF;
            end
            node_rank = RANK_INF;
            min_rank = RANK_INF;
            hop_limit = HOP_RESET;
            expected_q.delete();
            o_errors <= 0;
            o_words_in <= 0;
            o_words_out <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_MAX_HOP)
                hop_limit = i_pwdata[15:0];
            if (i_done) begin
                got = '{i_own_rank, i_preferred_parent, i_preferred_parent_rank,
                        i_preferred_changed, i_preferred_removed, i_rank_class_differs};
                o_words_out <= o_words_out + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected rank=%h pp=%h ppr=%h chg=%b rem=%b dif=%b",
                                 $time, exp_r.own_rank, exp_r.pref, exp_r.pref_rank,
                                 exp_r.changed, exp_r.removed, exp_r.differs);
                        $display("%0t:          actual   rank=%h pp=%h ppr=%h chg=%b rem=%b dif=%b",
                                 $time, got.own_rank, got.pref, got.pref_rank,
                                 got.changed, got.removed, got.differs);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_q.push_back(predict_advert(i_sender_address, i_advertised_rank,
                                                    i_offered_rank));
                o_words_in <= o_words_in + 1;
            end
        end
        o_pending <= expected_q.size();
    end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random neighbor advertisements into the parent set
// table in bursts, reprograms max_hop_increase between phases and reports
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
    import rps_pkg::*;

    localparam int WATCHDOG = 2000;
    localparam int N_RANDOM = 1530;
    localparam logic [2:0] ADDR_MAX_HOP = 3'd0;

    logic        i_clk, i_rst_n, i_start;
    logic [15:0] sa, ar, off;
    logic        busy, done;
    logic [15:0] own_rank, pp, ppr;
    logic        chg, rem, dif;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          errors, pending, words_in, words_out, idle_cycles;
    logic [15:0] addr_pool [6];

    routing_parent_set_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_sender_address(sa), .i_advertised_rank(ar), .i_offered_rank(off),
        .o_busy(busy), .o_done(done), .o_own_rank(own_rank),
        .o_preferred_parent(pp), .o_preferred_parent_rank(ppr),
        .o_preferred_changed(chg), .o_preferred_removed(rem),
        .o_rank_class_differs(dif),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rps_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(busy),
        .i_sender_address(sa), .i_advertised_rank(ar), .i_offered_rank(off),
        .i_done(done), .i_own_rank(own_rank), .i_preferred_parent(pp),
        .i_preferred_parent_rank(ppr), .i_preferred_changed(chg),
        .i_preferred_removed(rem), .i_rank_class_differs(dif),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending), .o_words_in(words_in),
        .o_words_out(words_out)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !busy) || done || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_advert(input logic [15:0] s, a, o);
        @(negedge i_clk);
        sa <= s;
        ar <= a;
        off <= o;
        i_start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_line(input int n);
        @(negedge i_clk);
        i_start <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        pause_line(1);
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (NUM_PARENTS + 8) @(negedge i_clk);
    endtask

    task automatic write_max_hop(input logic [15:0] v);
        drain();
        psel <= 1;
        pwrite <= 1;
        paddr <= ADDR_MAX_HOP;
        pwdata <= {16'h0, v};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    function automatic logic [15:0] pick_addr();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return addr_pool[$urandom_range(0, 5)];
    endfunction

    logic [15:0] base, o;
    int burst, kind;

    initial begin
        i_rst_n = 0;
        i_start = 0;
        sa = 0;
        ar = 0;
        off = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        idle_cycles = 0;
        addr_pool = '{16'h0001, 16'h0002, 16'h0003, 16'h8000, 16'hfffe, RANK_INF};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: fill, refresh, overflow, worse with siblings, removal
        send_advert(16'h0001, 16'h0100, 16'h0200);
        send_advert(16'h0002, 16'h0101, 16'h0203);
        send_advert(16'h0001, 16'h0000, 16'h0201);
        send_advert(16'h0003, 16'h0102, 16'h0207);
        send_advert(16'h0004, 16'h0103, 16'h0204);
        send_advert(16'h0005, 16'h0104, 16'h0205);
        send_advert(16'h0002, 16'h0105, 16'h0400);
        send_advert(16'h0001, 16'h0106, RANK_INF);
        send_advert(16'hffff, 16'hffff, RANK_INF);
        send_advert(16'h0009, 16'h0000, RANK_INF);
        // worse offers from a non-preferred sender, then better from scratch
        send_advert(16'h0004, 16'h0001, 16'h0300);
        send_advert(16'h0004, 16'h0002, 16'h0500);
        send_advert(16'h0004, 16'h0003, 16'hfffe);
        send_advert(16'h0007, 16'h0000, 16'h0000);
        send_advert(16'h0008, 16'h0000, 16'h0007);
        send_advert(16'hffff, 16'h1234, 16'h0001);
        send_advert(16'h0007, 16'hffff, 16'hfff0);
        write_max_hop(16'hffff);
        send_advert(16'h0007, 16'h0010, 16'hfffe);
        write_max_hop(16'h0000);
        send_advert(16'h0007, 16'h0011, 16'h0001);
        send_advert(16'h0007, 16'h0011, 16'h0010);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 300 == 150) begin
                case ((i / 300) % 4)
                    0: write_max_hop(16'hffff);
                    1: write_max_hop(16'h0000);
                    2: write_max_hop(16'($urandom_range(1, 64)));
                    default: write_max_hop(HOP_RESET);
                endcase
            end
            if (i == 700) drain();
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) pause_line($urandom_range(1, 12));
            end
            burst--;
            base = (own_rank == RANK_INF) ? 16'($urandom_range(0, 4000)) : own_rank;
            kind = $urandom_range(0, 99);
            if (kind < 12) o = RANK_INF;
            else if (kind < 20) o = 16'($urandom);
            else if (kind < 45) o = {base[15:3], 3'($urandom)};
            else if (kind < 60) o = base - 16'($urandom_range(8, 64));
            else o = base + 16'($urandom_range(8, 2000));
            if (o == RANK_INF && kind >= 12) o = 16'hfffe;
            send_advert(pick_addr(), 16'($urandom), o);
        end

        drain();
        $display("Covered %0d advertisements and %0d result words,", words_in, words_out);
        $display("with max_hop_increase swept over its extremes.");
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial burst = 0;
endmodule
